[design/va_pkg.sv]
// ----------------------------------------------------------------------------
// va_pkg
// shared types and constants for the voice allocator: port payloads, the
// classified queue entry, event codes and the back-end sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package va_pkg;

	localparam int VA_VOICE_COUNT = 6;
	localparam int VA_NOTE_W      = 7;
	localparam int VA_VEL_W       = 7;
	localparam int VA_TIME_W      = 32;
	localparam int VA_SLOT_W      = 3;
	localparam int VA_STATUS_W    = 3;

	// command queue between front and back, depth must be a power of two
	localparam int VA_QUEUE_DEPTH = 2;
	localparam int VA_QPTR_W      = (VA_QUEUE_DEPTH > 1) ? $clog2(VA_QUEUE_DEPTH) : 1;
	localparam int VA_QCNT_W      = $clog2(VA_QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_NOTE_ON  = 1'b0,
		CMD_NOTE_OFF = 1'b1
	} va_cmd_e;

	typedef enum logic [VA_STATUS_W-1:0] {
		ST_FREE      = 3'd0,
		ST_STOLEN    = 3'd1,
		ST_RELEASED  = 3'd2,
		ST_UNMATCHED = 3'd3,
		ST_NONE      = 3'd4
	} va_status_e;

	typedef enum logic {
		BK_DECIDE = 1'b0,
		BK_SCAN   = 1'b1
	} va_bk_state_e;

	typedef struct packed {
		logic                 command;
		logic [VA_NOTE_W-1:0] note_number;
		logic [VA_VEL_W-1:0]  note_velocity;
		logic [VA_TIME_W-1:0] time_stamp;
	} va_in_t;

	typedef struct packed {
		logic [VA_SLOT_W-1:0]   voice_slot;
		logic [VA_STATUS_W-1:0] event_status;
		logic [VA_NOTE_W-1:0]   stolen_note;
		logic                   gate_on;
	} va_out_t;

	typedef struct packed {
		va_cmd_e              op;
		logic [VA_NOTE_W-1:0] note;
		logic [VA_VEL_W-1:0]  velocity;
		logic [VA_TIME_W-1:0] start_time;
	} va_entry_t;

	typedef struct packed {
		logic      valid;
		va_entry_t entry;
	} va_qhead_t;

endpackage : va_pkg

`default_nettype wire

[design/va_front.sv]
// ----------------------------------------------------------------------------
// va_front
// takes command beats, classifies them into queue entries and holds them in
// a short queue until the back end is free to carry them out
// ----------------------------------------------------------------------------
`default_nettype none

module va_front import va_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire va_in_t    item,
	output logic           busy,
	input  wire logic      pop,
	output va_qhead_t      head
);

	va_entry_t              fifo_q [VA_QUEUE_DEPTH];
	logic [VA_QPTR_W-1:0]   wr_ptr_q;
	logic [VA_QPTR_W-1:0]   rd_ptr_q;
	logic [VA_QCNT_W-1:0]   count_q;
	logic                   push;
	va_entry_t              new_entry;

	assign busy = (count_q == VA_QCNT_W'(VA_QUEUE_DEPTH));
	assign push = start && !busy;

	always_comb begin
		new_entry.op         = (item.command == 1'b1) ? CMD_NOTE_OFF : CMD_NOTE_ON;
		new_entry.note       = item.note_number;
		new_entry.velocity   = item.note_velocity;
		new_entry.start_time = item.time_stamp;
	end

	assign head.valid = (count_q != '0);
	assign head.entry = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= VA_QCNT_W'(VA_QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !pop |=> busy)
		else $error("full queue drained without a pop");

endmodule : va_front

`default_nettype wire

[design/va_back.sv]
// ----------------------------------------------------------------------------
// va_back
// voice slot table and its sequencer: note off and note on with a free voice
// finish from the decide state, a steal walks start times one slot per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module va_back import va_pkg::*; #(
	parameter int VOICE_COUNT = VA_VOICE_COUNT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire va_qhead_t head,
	output logic           pop,
	output logic           done,
	output va_out_t        result
);

	localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

	logic [VOICE_COUNT-1:0] active_q;
	logic [VA_NOTE_W-1:0]   note_q [VOICE_COUNT];
	logic [VA_VEL_W-1:0]    vel_q  [VOICE_COUNT];
	logic [VA_TIME_W-1:0]   time_q [VOICE_COUNT];

	va_bk_state_e           state_q, state_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [VA_TIME_W-1:0]   best_q, best_d;
	logic [IDX_W-1:0]       pick_q, pick_d;
	logic                   found_q, found_d;
	logic [VA_NOTE_W-1:0]   stolen_q, stolen_d;

	logic                   done_q;
	va_out_t                result_q;

	logic                   free_any;
	logic [IDX_W-1:0]       free_idx;
	logic                   match_any;
	logic [IDX_W-1:0]       match_idx;

	logic [VA_TIME_W-1:0]   scan_time;
	logic                   less;
	logic                   scan_last;
	logic                   fin_found;
	logic [IDX_W-1:0]       fin_pick;
	logic [VA_NOTE_W-1:0]   fin_stolen;

	logic                   emit;
	logic                   wr_on;
	logic                   wr_off;
	logic [IDX_W-1:0]       wr_idx;
	logic [IDX_W+2:0]       wr_wide;
	logic [VA_STATUS_W-1:0] res_status;
	logic [VA_NOTE_W-1:0]   res_stolen;
	logic                   res_gate;

	// lowest free voice and lowest active voice holding the note
	always_comb begin
		free_any  = 1'b0;
		free_idx  = '0;
		match_any = 1'b0;
		match_idx = '0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
			if (active_q[i] && (note_q[i] == head.entry.note)) begin
				match_any = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
	end

	// oldest-voice walk, strictly smaller wins so the lowest index keeps a tie
	assign scan_time  = time_q[idx_q];
	assign less       = (scan_time < best_q);
	assign scan_last  = (idx_q == LAST_IDX);
	assign fin_found  = less || found_q;
	assign fin_pick   = less ? idx_q : pick_q;
	assign fin_stolen = less ? note_q[idx_q] : stolen_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_DECIDE: begin
				if (head.valid && (head.entry.op == CMD_NOTE_ON) && !free_any) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_last) begin
					state_d = BK_DECIDE;
				end
			end
			default: state_d = BK_DECIDE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		emit       = 1'b0;
		wr_on      = 1'b0;
		wr_off     = 1'b0;
		wr_idx     = '0;
		res_status = ST_NONE;
		res_stolen = '0;
		res_gate   = 1'b0;
		idx_d      = idx_q;
		best_d     = best_q;
		pick_d     = pick_q;
		found_d    = found_q;
		stolen_d   = stolen_q;
		case (state_q)
			BK_DECIDE: begin
				if (head.valid) begin
					if (head.entry.op == CMD_NOTE_OFF) begin
						pop  = 1'b1;
						emit = 1'b1;
						if (match_any) begin
							wr_off     = 1'b1;
							wr_idx     = match_idx;
							res_status = ST_RELEASED;
						end else begin
							res_status = ST_UNMATCHED;
						end
					end else if (free_any) begin
						pop        = 1'b1;
						emit       = 1'b1;
						wr_on      = 1'b1;
						wr_idx     = free_idx;
						res_status = ST_FREE;
						res_gate   = 1'b1;
					end else begin
						idx_d    = '0;
						best_d   = '1;
						pick_d   = '0;
						found_d  = 1'b0;
						stolen_d = '0;
					end
				end
			end
			BK_SCAN: begin
				if (scan_last) begin
					pop  = 1'b1;
					emit = 1'b1;
					if (fin_found) begin
						wr_on      = 1'b1;
						wr_idx     = fin_pick;
						res_status = ST_STOLEN;
						res_stolen = fin_stolen;
						res_gate   = 1'b1;
					end else begin
						res_status = ST_NONE;
					end
				end else begin
					idx_d = idx_q + 1'b1;
					if (less) begin
						best_d   = scan_time;
						pick_d   = idx_q;
						found_d  = 1'b1;
						stolen_d = note_q[idx_q];
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// slot number is reported in three bits
	assign wr_wide = {3'b000, wr_idx};

	always_ff @(posedge clk) begin
		if (wr_on) begin
			note_q[wr_idx] <= head.entry.note;
			vel_q[wr_idx]  <= head.entry.velocity;
			time_q[wr_idx] <= head.entry.start_time;
		end else if (wr_off) begin
			note_q[wr_idx] <= '0;
		end
		idx_q    <= idx_d;
		best_q   <= best_d;
		pick_q   <= pick_d;
		found_q  <= found_d;
		stolen_q <= stolen_d;
		if (emit) begin
			result_q.voice_slot   <= wr_wide[2:0];
			result_q.event_status <= res_status;
			result_q.stolen_note  <= res_stolen;
			result_q.gate_on      <= res_gate;
		end
	end

	// velocity is held for the voice but nothing downstream reads it here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			state_q  <= BK_DECIDE;
			done_q   <= 1'b0;
		end else begin
			if (wr_on) begin
				active_q[wr_idx] <= 1'b1;
			end else if (wr_off) begin
				active_q[wr_idx] <= 1'b0;
			end
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_scan_steal_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |-> head.valid && (head.entry.op == CMD_NOTE_ON) && (&active_q))
		else $error("voice walk without a pending steal");

	a_pop_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> done)
		else $error("command retired without a result beat");

	a_steal_gates: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.event_status == ST_STOLEN || result.event_status == ST_FREE)
			|-> result.gate_on)
		else $error("started voice without gate");

	a_start_fills: assert property (@(posedge clk) disable iff (!arst_n)
		wr_on |=> active_q[$past(wr_idx)])
		else $error("started voice not marked active");

endmodule : va_back

`default_nettype wire

[design/voice_allocator_oldest_steal.sv]
// a command is registered into the queue, decided by the back end and its
//   result registered; a steal first walks every slot's start time
// throughput: one command per cycle while voices are free or for note off;
//   a steal holds the back end while it walks the slots (one slot per cycle)
// the receiver cannot stall: done is a single-cycle strobe
// reset clears all voices to inactive and empties the command queue
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal
// polyphonic voice allocator with oldest-note stealing: a command queue in
// front of a slot table that starts and releases voices
// ----------------------------------------------------------------------------
`default_nettype none

module voice_allocator_oldest_steal import va_pkg::*; #(
	parameter int VOICE_COUNT = VA_VOICE_COUNT
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire va_in_t item,
	output logic        done,
	output va_out_t     result
);

	va_qhead_t head;
	logic      pop;

	va_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (head)
	);

	va_back #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule : voice_allocator_oldest_steal

`default_nettype wire

[verif/tb_voice_allocator_oldest_steal.sv]
// ----------------------------------------------------------------------------
// tb_voice_allocator_oldest_steal
// drives note-on and note-off commands into the voice allocator with random
// gaps, tracks the slot table alongside it and checks every result beat in
// order: directed corner cases first, then a long random run biased towards
// a full table so that stealing, ties and releases happen often
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voice_allocator_oldest_steal;

	timeunit 1ns;
	timeprecision 1ps;

	import va_pkg::*;

	localparam int RANDOM_BEATS = 1850;
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX   = 10;

	// ------------------------------------------------------------------------
	// slot table tracker and result checker
	// ------------------------------------------------------------------------
	class voice_scoreboard;
		bit                   active[VA_VOICE_COUNT];
		logic [VA_NOTE_W-1:0] held_note[VA_VOICE_COUNT];
		logic [VA_VEL_W-1:0]  held_vel[VA_VOICE_COUNT];
		logic [VA_TIME_W-1:0] began[VA_VOICE_COUNT];
		va_out_t              awaited[$];
		int                   errors;

		function new();
			for (int i = 0; i < VA_VOICE_COUNT; i++) begin
				active[i]    = 1'b0;
				held_note[i] = '0;
				held_vel[i]  = '0;
				began[i]     = '0;
			end
			errors = 0;
		endfunction

		function void note_input(va_in_t b);
			va_out_t              r;
			int                   pick;
			logic [VA_TIME_W-1:0] oldest;
			r    = '0;
			pick = -1;
			if (b.command == CMD_NOTE_ON) begin
				r.event_status = ST_FREE;
				for (int i = 0; i < VA_VOICE_COUNT; i++) begin
					if (!active[i] && pick < 0)
						pick = i;
				end
				if (pick < 0) begin
					// strictly older wins, so an all-ones start time is never taken
					oldest = '1;
					for (int i = 0; i < VA_VOICE_COUNT; i++) begin
						if (began[i] < oldest) begin
							oldest = began[i];
							pick   = i;
						end
					end
					if (pick >= 0) begin
						r.event_status = ST_STOLEN;
						r.stolen_note  = held_note[pick];
					end
				end
				if (pick < 0) begin
					r.event_status = ST_NONE;
				end else begin
					active[pick]    = 1'b1;
					held_note[pick] = b.note_number;
					held_vel[pick]  = b.note_velocity;
					began[pick]     = b.time_stamp;
					r.voice_slot    = pick[VA_SLOT_W-1:0];
					r.gate_on       = 1'b1;
				end
			end else begin
				for (int i = 0; i < VA_VOICE_COUNT; i++) begin
					if (pick < 0 && active[i] && held_note[i] == b.note_number)
						pick = i;
				end
				if (pick < 0) begin
					r.event_status = ST_UNMATCHED;
				end else begin
					active[pick]    = 1'b0;
					held_note[pick] = '0;
					r.voice_slot    = pick[VA_SLOT_W-1:0];
					r.event_status  = ST_RELEASED;
				end
			end
			awaited.push_back(r);
		endfunction

		function void check_result(va_out_t got);
			va_out_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: result beat with nothing outstanding: slot %0d status %0d",
						$realtime, got.voice_slot, got.event_status);
				return;
			end
			want = awaited.pop_front();
			if (got.voice_slot !== want.voice_slot || got.event_status !== want.event_status ||
					got.stolen_note !== want.stolen_note || got.gate_on !== want.gate_on) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: mismatch exp slot %0d status %0d stolen %0d gate %0d,",
						$realtime, want.voice_slot, want.event_status, want.stolen_note,
						want.gate_on);
					$display("    got slot %0d status %0d stolen %0d gate %0d",
						got.voice_slot, got.event_status, got.stolen_note, got.gate_on);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and the block
	// ------------------------------------------------------------------------
	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	va_in_t  item   = '0;
	logic    busy;
	logic    done;
	va_out_t result;

	voice_scoreboard      sb;
	int                   cycle_count = 0;
	int                   burst_left  = 0;
	logic [VA_TIME_W-1:0] clock_ms    = '0;

	always #2 clk = ~clk;

	voice_allocator_oldest_steal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// beats are taken and results checked on the same edge the block sees them
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_input(item);
			if (done)
				sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_voice_allocator_oldest_steal: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	function automatic va_in_t make_cmd(logic cmd, int unsigned note, int unsigned vel,
			logic [VA_TIME_W-1:0] ts);
		va_in_t b;
		b.command       = cmd;
		b.note_number   = note[VA_NOTE_W-1:0];
		b.note_velocity = vel[VA_VEL_W-1:0];
		b.time_stamp    = ts;
		return b;
	endfunction

	function automatic va_in_t any_item();
		return make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 127),
			$urandom_range(0, 127), $urandom);
	endfunction

	// mostly a small pool of notes so that note off finds its voice,
	// time mostly creeping forward with ties, now and then wild or all ones
	function automatic va_in_t random_cmd();
		int unsigned          roll;
		int unsigned          note;
		logic                 cmd;
		logic [VA_TIME_W-1:0] ts;
		cmd  = ($urandom_range(0, 99) < 45) ? CMD_NOTE_OFF : CMD_NOTE_ON;
		note = ($urandom_range(0, 9) < 7) ? $urandom_range(60, 67) : $urandom_range(0, 127);
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			clock_ms = $urandom;
			ts       = clock_ms;
		end else if (roll < 6) begin
			ts = '1;
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 2);
			ts       = clock_ms;
		end
		return make_cmd(cmd, note, $urandom_range(0, 127), ts);
	endfunction

	function automatic int pick_gap();
		int unsigned roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			burst_left = $urandom_range(20, 60);
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(input va_in_t b);
		item  <= b;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic hold_idle(input int n);
		if (n > 0) begin
			start <= 1'b0;
			item  <= any_item();
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_then_gap(input va_in_t b);
		send_beat(b);
		hold_idle(pick_gap());
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: note off finds nothing
		send_then_gap(make_cmd(CMD_NOTE_OFF, 5, 127, 32'h0));
		// fill every voice with start times that can never be stolen
		send_then_gap(make_cmd(CMD_NOTE_ON, 0, 127, '1));
		send_then_gap(make_cmd(CMD_NOTE_ON, 127, 0, '1));
		send_then_gap(make_cmd(CMD_NOTE_ON, 10, 1, '1));
		send_then_gap(make_cmd(CMD_NOTE_ON, 11, 64, '1));
		send_then_gap(make_cmd(CMD_NOTE_ON, 12, 85, '1));
		send_then_gap(make_cmd(CMD_NOTE_ON, 13, 42, '1));
		// nothing stealable
		send_then_gap(make_cmd(CMD_NOTE_ON, 50, 99, 32'h0));
		// note zero is a real note
		send_then_gap(make_cmd(CMD_NOTE_OFF, 0, 0, '1));
		send_then_gap(make_cmd(CMD_NOTE_ON, 20, 33, 32'd100));
		// steals of the only finite start time, then a freed voice refilled
		send_then_gap(make_cmd(CMD_NOTE_ON, 21, 34, 32'd0));
		send_then_gap(make_cmd(CMD_NOTE_ON, 22, 35, 32'd5));
		send_then_gap(make_cmd(CMD_NOTE_OFF, 127, 127, 32'h5555_AAAA));
		send_then_gap(make_cmd(CMD_NOTE_ON, 23, 36, 32'd5));
		// two voices tied on start time: lowest index goes
		send_then_gap(make_cmd(CMD_NOTE_ON, 24, 37, 32'h8000_0000));
		send_then_gap(make_cmd(CMD_NOTE_ON, 25, 38, 32'hFFFF_FFFE));
		// unmatched off, then duplicates released lowest first
		send_then_gap(make_cmd(CMD_NOTE_OFF, 99, 127, 32'h0));
		send_then_gap(make_cmd(CMD_NOTE_OFF, 11, 0, 32'h0));
		send_then_gap(make_cmd(CMD_NOTE_OFF, 12, 0, 32'h0));
		send_then_gap(make_cmd(CMD_NOTE_ON, 70, 10, 32'd7));
		send_then_gap(make_cmd(CMD_NOTE_ON, 70, 11, 32'd7));
		send_then_gap(make_cmd(CMD_NOTE_OFF, 70, 0, 32'd0));
		send_then_gap(make_cmd(CMD_NOTE_OFF, 70, 0, 32'd0));
		send_then_gap(make_cmd(CMD_NOTE_OFF, 70, 0, 32'd0));

		for (int n = 0; n < RANDOM_BEATS; n++)
			send_then_gap(random_cmd());

		start <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (VA_VOICE_COUNT + 4) @(posedge clk);

		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("tb_voice_allocator_oldest_steal: PASS");
		else
			$display("tb_voice_allocator_oldest_steal: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
